>>> rtl/postfix_expression_evaluator_defines.svh
// Assertion macros for the postfix expression evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PEE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PEE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/pee_pkg.sv
// Types and constants shared by the postfix evaluator modules.
package pee_pkg;
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1,
		OP_POW = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_sts_t;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_POW   = 8'h5E;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [31:0] POP_EMPTY = 32'hFFFF_FFFF;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_OVF  = 3'd1;
	localparam logic [2:0] ST_UDF  = 3'd2;
	localparam logic [2:0] ST_DIVZ = 3'd3;
	localparam logic [2:0] ST_MULT = 3'd4;
endpackage

>>> rtl/pee_alu.sv
// Shared multi-cycle unit: shift-add multiply, restoring divide, square-and-multiply power.
module pee_alu import pee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  alu_ctl_t    ctl,
	input  logic [31:0] opb,
	input  logic [31:0] opa,
	output alu_sts_t    sts,
	output logic [31:0] result
);
	typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_PSQ, S_PACC, S_DONE} alu_state_t;

	alu_state_t  state_q;
	logic [31:0] x_q;     // divisor magnitude / base and its squares
	logic [31:0] y_q;     // dividend-quotient / exponent
	logic [31:0] acc_q;   // product / remainder / power accumulator
	logic [31:0] m_q;     // multiplier being consumed in a multiply
	logic [31:0] p_q;     // partial product
	logic [31:0] src_q;   // value multiplied in during multiply and power steps
	logic [5:0]  cnt_q;
	logic [4:0]  bit_q;
	logic        neg_q;
	logic        dz_q;

	logic [32:0] rem_try;
	assign rem_try = {acc_q, y_q[31]} - {1'b0, x_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q <= '0; y_q <= '0; acc_q <= '0; m_q <= '0; p_q <= '0; src_q <= '0;
			cnt_q <= '0; bit_q <= '0; neg_q <= 1'b0; dz_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						dz_q <= (ctl.op == OP_DIV) && (opa == '0);
						cnt_q <= '0;
						unique case (ctl.op)
							OP_MUL: begin
								p_q <= '0; src_q <= opb; m_q <= opa;
								state_q <= S_MUL;
							end
							OP_DIV: begin
								if (opa == '0) begin
									acc_q <= '0; state_q <= S_DONE;
								end else begin
									x_q <= opa[31] ? -opa : opa;
									y_q <= opb[31] ? -opb : opb;
									neg_q <= opa[31] ^ opb[31];
									acc_q <= '0;
									state_q <= S_DIV;
								end
							end
							default: begin
								if (opa[31]) begin
									if (opb == 32'd1) acc_q <= 32'd1;
									else if (opb == POP_EMPTY) acc_q <= opa[0] ? POP_EMPTY : 32'd1;
									else acc_q <= '0;
									state_q <= S_DONE;
								end else begin
									acc_q <= 32'd1; x_q <= opb; y_q <= opa; bit_q <= '0;
									state_q <= S_PACC;
								end
							end
						endcase
					end
				end
				S_MUL: begin
					// One multiplier bit per cycle.
					if (m_q[0]) p_q <= p_q + src_q;
					src_q <= src_q << 1;
					m_q <= m_q >> 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						acc_q <= m_q[0] ? p_q + src_q : p_q;
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					y_q <= {y_q[30:0], ~rem_try[32]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						acc_q <= neg_q ? -{y_q[30:0], ~rem_try[32]} : {y_q[30:0], ~rem_try[32]};
						state_q <= S_DONE;
					end else if (!rem_try[32]) begin
						acc_q <= rem_try[31:0];
					end else begin
						acc_q <= {acc_q[30:0], y_q[31]};
					end
				end
				S_PACC: begin
					// Nested shift-add multiply: acc*x when the exponent bit is set, then x*x.
					if (cnt_q == 6'd0) begin
						p_q <= '0;
						src_q <= y_q[bit_q] ? acc_q : '0;
						m_q <= x_q;
						cnt_q <= 6'd1;
					end else begin
						if (m_q[0]) p_q <= p_q + src_q;
						src_q <= src_q << 1;
						m_q <= m_q >> 1;
						if (cnt_q == 6'd32) begin
							if (y_q[bit_q]) acc_q <= m_q[0] ? p_q + src_q : p_q;
							cnt_q <= '0;
							state_q <= S_PSQ;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				S_PSQ: begin
					if (cnt_q == 6'd0) begin
						p_q <= '0; src_q <= x_q; m_q <= x_q; cnt_q <= 6'd1;
						if (bit_q == 5'd30 || (y_q >> bit_q) == 32'd1) state_q <= S_DONE;
					end else begin
						if (m_q[0]) p_q <= p_q + src_q;
						src_q <= src_q << 1;
						m_q <= m_q >> 1;
						if (cnt_q == 6'd32) begin
							x_q <= m_q[0] ? p_q + src_q : p_q;
							cnt_q <= '0;
							bit_q <= bit_q + 5'd1;
							state_q <= S_PACC;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sts.done = (state_q == S_DONE);
	assign sts.div_zero = dz_q;
	assign result = acc_q;
endmodule

>>> rtl/postfix_expression_evaluator.sv
// Top level: character decoder, stack sequencer and shared arithmetic unit.
//  channel | dir | handshake     | payload
//  in      | in  | in_valid/stall| in_item_t  (char_code, last_char)
//  out     | out | out_valid/stall| out_item_t (value, status)
// Each character is finished before the next is taken: a digit is pushed, an ignored
// one dropped, + and - computed here; * and / (a zero divisor finishes early) and ^
// wait on the bit-serial shared arithmetic unit. The last character adds the final pop
// and a pass through the output register.
// Reset empties the stack and clears the error flags at once; stack contents are left.
// A stalled result holds in the output register; no new item is taken until it leaves.
`include "postfix_expression_evaluator_defines.svh"
module postfix_expression_evaluator import pee_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);

	typedef enum logic [2:0] {T_IDLE, T_POPA, T_POPB, T_EXEC, T_WAIT, T_PUSH, T_FINAL, T_OUT}
		top_state_t;

	top_state_t    state_q;
	in_item_t      item_q;
	logic [PW-1:0] sp_q;
	logic [2:0]    flags_q;
	logic [31:0]   a_q, b_q, r_q;
	logic [31:0]   mem [STACK_DEPTH];
	logic [31:0]   rd_q;
	alu_ctl_t      alu_ctl;
	alu_sts_t      alu_sts;
	logic [31:0]   alu_res;

	logic is_digit, is_op;
	assign is_digit = (item_q.char_code >= CH_0) && (item_q.char_code <= CH_9);
	assign is_op = (item_q.char_code == CH_POW) || (item_q.char_code == CH_DIV) ||
		(item_q.char_code == CH_MUL) || (item_q.char_code == CH_ADD) ||
		(item_q.char_code == CH_SUB);

	logic [PW-1:0] sp_m1;
	assign sp_m1 = sp_q - PW'(1);

	// Registered read of the top-of-stack entry, and the push write.
	always_ff @(posedge clk) begin
		rd_q <= mem[sp_m1[AW-1:0]];
		if (state_q == T_PUSH && sp_q < DEPTH_P) mem[sp_q[AW-1:0]] <= r_q;
	end

	pee_alu u_alu (.clk, .arst_n, .ctl(alu_ctl), .opb(b_q), .opa(a_q), .sts(alu_sts),
		.result(alu_res));

	always_comb begin
		alu_ctl.start = (state_q == T_EXEC) &&
			(item_q.char_code == CH_MUL || item_q.char_code == CH_DIV ||
			item_q.char_code == CH_POW);
		unique case (item_q.char_code)
			CH_DIV:  alu_ctl.op = OP_DIV;
			CH_POW:  alu_ctl.op = OP_POW;
			default: alu_ctl.op = OP_MUL;
		endcase
	end

	logic [2:0] st_code;
	always_comb begin
		unique case (flags_q)
			3'b000:  st_code = ST_OK;
			3'b001:  st_code = ST_OVF;
			3'b010:  st_code = ST_UDF;
			3'b100:  st_code = ST_DIVZ;
			default: st_code = ST_MULT;
		endcase
	end

	// Each pop waits through a gap state so that the registered read reflects the current top.
	logic gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			sp_q <= '0;
			flags_q <= '0;
			gap_q <= 1'b0;
			out_valid <= 1'b0;
			item_q <= '0;
			a_q <= '0; b_q <= '0; r_q <= '0;
			out_item <= '0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						gap_q <= 1'b0;
						state_q <= T_POPA;
					end
				end
				T_POPA: begin
					if (is_digit) begin
						r_q <= {28'd0, item_q.char_code[3:0]};
						state_q <= T_PUSH;
					end else if (!is_op) begin
						state_q <= item_q.last_char ? T_FINAL : T_IDLE;
					end else if (!gap_q) begin
						gap_q <= 1'b1;
					end else begin
						gap_q <= 1'b0;
						if (sp_q == '0) begin
							a_q <= POP_EMPTY; flags_q[1] <= 1'b1;
						end else begin
							a_q <= rd_q; sp_q <= sp_m1;
						end
						state_q <= T_POPB;
					end
				end
				T_POPB: begin
					if (!gap_q) begin
						gap_q <= 1'b1;
					end else begin
						gap_q <= 1'b0;
						if (sp_q == '0) begin
							b_q <= POP_EMPTY; flags_q[1] <= 1'b1;
						end else begin
							b_q <= rd_q; sp_q <= sp_m1;
						end
						state_q <= T_EXEC;
					end
				end
				T_EXEC: begin
					case (item_q.char_code)
						CH_ADD: begin r_q <= b_q + a_q; state_q <= T_PUSH; end
						CH_SUB: begin r_q <= b_q - a_q; state_q <= T_PUSH; end
						default: state_q <= T_WAIT;
					endcase
				end
				T_WAIT: begin
					if (alu_sts.done) begin
						r_q <= alu_res;
						if (alu_sts.div_zero) flags_q[2] <= 1'b1;
						state_q <= T_PUSH;
					end
				end
				T_PUSH: begin
					if (sp_q < DEPTH_P) sp_q <= sp_q + PW'(1);
					else flags_q[0] <= 1'b1;
					gap_q <= 1'b0;
					state_q <= item_q.last_char ? T_FINAL : T_IDLE;
				end
				T_FINAL: begin
					if (!gap_q) begin
						gap_q <= 1'b1;
					end else begin
						gap_q <= 1'b0;
						out_item.value <= (sp_q == '0) ? POP_EMPTY : rd_q;
						out_item.status <= (sp_q == '0) ? ((flags_q | 3'b010) == 3'b010 ?
							ST_UDF : ST_MULT) : st_code;
						out_valid <= 1'b1;
						sp_q <= '0;
						flags_q <= '0;
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != T_IDLE);

	`PEE_ASSERT_IMP(a_sp_range, 1'b1, sp_q <= DEPTH_P)
	`PEE_ASSERT_IMP(a_busy_no_take, out_valid, in_stall)
	`PEE_ASSERT_NXT(a_out_clears, out_valid && !out_stall, !out_valid && sp_q == '0)
endmodule

>>> verif/postfix_expression_evaluator_tb.sv
// Postfix expression evaluator testbench: directed and random expressions checked by a predictor.
`timescale 1ns / 100ps

class expr_scoreboard;
	logic [31:0] stk [16];
	int          depth;
	logic [2:0]  flags;
	pee_pkg::out_item_t results_q[$];
	int          errors;

	function new();
		depth = 0;
		flags = 3'b000;
		errors = 0;
	endfunction

	function logic [31:0] pop_value();
		if (depth == 0) begin
			flags[1] = 1'b1;
			return pee_pkg::POP_EMPTY;
		end
		depth--;
		return stk[depth];
	endfunction

	function void push_value(logic [31:0] v);
		if (depth >= 16) begin
			flags[0] = 1'b1;
		end else begin
			stk[depth] = v;
			depth++;
		end
	endfunction

	function logic [31:0] power(logic [31:0] b, logic [31:0] e);
		logic [31:0] acc;
		logic [31:0] sq;
		acc = 32'd1;
		sq = b;
		if (e[31]) begin
			if (b == 32'd1) return 32'd1;
			if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
			return 32'd0;
		end
		for (int k = 0; k < 31; k++) begin
			if (e[k]) acc = acc * sq;
			sq = sq * sq;
		end
		return acc;
	endfunction

	function logic [31:0] divide(logic [31:0] n, logic [31:0] d);
		logic [31:0] nm;
		logic [31:0] dm;
		logic [31:0] q;
		if (d == 32'd0) begin
			flags[2] = 1'b1;
			return 32'd0;
		end
		nm = n[31] ? -n : n;
		dm = d[31] ? -d : d;
		q = nm / dm;
		return (n[31] != d[31]) ? -q : q;
	endfunction

	function void note_char(pee_pkg::in_item_t it);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		pee_pkg::out_item_t res;
		if (it.char_code >= pee_pkg::CH_0 && it.char_code <= pee_pkg::CH_9) begin
			push_value(32'(it.char_code - pee_pkg::CH_0));
		end else if (it.char_code == pee_pkg::CH_POW || it.char_code == pee_pkg::CH_DIV ||
				it.char_code == pee_pkg::CH_MUL || it.char_code == pee_pkg::CH_ADD ||
				it.char_code == pee_pkg::CH_SUB) begin
			a = pop_value();
			b = pop_value();
			case (it.char_code)
				pee_pkg::CH_POW: r = power(b, a);
				pee_pkg::CH_DIV: r = divide(b, a);
				pee_pkg::CH_MUL: r = b * a;
				pee_pkg::CH_ADD: r = b + a;
				default:         r = b - a;
			endcase
			push_value(r);
		end
		if (it.last_char) begin
			res.value = pop_value();
			case (flags)
				3'b000:  res.status = pee_pkg::ST_OK;
				3'b001:  res.status = pee_pkg::ST_OVF;
				3'b010:  res.status = pee_pkg::ST_UDF;
				3'b100:  res.status = pee_pkg::ST_DIVZ;
				default: res.status = pee_pkg::ST_MULT;
			endcase
			results_q.push_back(res);
			depth = 0;
			flags = 3'b000;
		end
	endfunction

	function void check_result(pee_pkg::out_item_t got);
		pee_pkg::out_item_t want;
		if (results_q.size() == 0) begin
			$display("%0t: unexpected result value=%0d status=%0d", $time, got.value, got.status);
			errors++;
			return;
		end
		want = results_q.pop_front();
		if (got.value !== want.value) begin
			$display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
			errors++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			errors++;
		end
	endfunction
endclass

module postfix_expression_evaluator_tb;
	import pee_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	logic      stall_hold;

	expr_scoreboard sb;

	postfix_expression_evaluator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Mostly small operand digits keep power quick; exponents stay small too.
	function automatic logic [7:0] rand_char();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return CH_0 + 8'($urandom_range(0, 9));
		if (p < 55) return CH_ADD;
		if (p < 65) return CH_SUB;
		if (p < 75) return CH_MUL;
		if (p < 83) return CH_DIV;
		if (p < 88) return CH_POW;
		return 8'($urandom_range(0, 255));
	endfunction

	// Valid stays high into the next item when there is no gap.
	task automatic send_char(input logic [7:0] c, input logic last);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_item.char_code <= c;
		in_item.last_char <= last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_char('{char_code: c, last_char: last});
		@(negedge clk);
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_expr(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	// Receiver: stall pattern changes at falling edges, result taken at rising edges.
	always @(negedge clk) begin
		if (stall_hold) begin
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: out_stall <= 1'b1;
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_item);
	end

	initial begin
		#80_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int n;
		int len;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		stall_hold = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed expressions: each operator, edge cases, overflow, underflow.
		send_expr("23^");
		send_expr("84/");
		send_expr("70/");
		send_expr("9*");
		send_expr("12-3-4^");
		send_expr("9999999999999999999");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b0);
		send_char(CH_ADD, 1'b1);
		send_expr("05-3^");
		send_expr("01-03-^");

		// Hold off until every pending result has drained.
		idle_input();
		while (sb.results_q.size() != 0) @(negedge clk);

		n = 52;
		while (n < 900) begin
			len = $urandom_range(1, 12);
			if ($urandom_range(0, 19) == 0) len = $urandom_range(14, 22);
			for (int i = 0; i < len; i++) begin
				logic [7:0] c;
				c = rand_char();
				// Most exponents are kept short by pushing a small digit before power.
				if (c == CH_POW && $urandom_range(0, 3) != 0) begin
					send_char(CH_0 + 8'($urandom_range(0, 4)), 1'b0);
					n++;
				end
				send_char(c, i == len - 1);
				n++;
			end
			if (n > 450 && n < 470) begin
				idle_input();
				stall_hold = 1'b1;
				while (sb.results_q.size() != 0) @(negedge clk);
				stall_hold = 1'b0;
			end
		end

		idle_input();
		while (sb.results_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

>>> postfix_expression_evaluator.f
+incdir+rtl
rtl/pee_pkg.sv
rtl/pee_alu.sv
rtl/postfix_expression_evaluator.sv
verif/postfix_expression_evaluator_tb.sv
